>>> rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths and codes of the fixed block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int STRIDE_W   = 16;
  localparam int BIU_W      = 9;
  localparam int LIM_W      = STRIDE_W + IDX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STRIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd3;

  // reset values
  localparam logic [SIZE_W-1:0]   RST_BLOCK_SIZE = 16'd64;
  localparam logic [STRIDE_W-1:0] RST_STRIDE     = 16'd64;
  localparam logic [ADDR_W-1:0]   RST_BASE       = 32'd4096;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_LARGE     = 3'd1,
    ST_OUT_OF_BLOCKS = 3'd2,
    ST_NULL_RELEASE  = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_e;

endpackage

`default_nettype wire

>>> rtl/fbpa_req_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel: command, requested size and release address.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [fbpa_pkg::SIZE_W-1:0]   req_size;
  logic [fbpa_pkg::ADDR_W-1:0]   release_addr;

  modport source (output valid, output cmd, output req_size, output release_addr,
                  input ready);
  modport sink   (input valid, input cmd, input req_size, input release_addr,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/fbpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Response channel: block address and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::ADDR_W-1:0]   block_addr;
  fbpa_pkg::status_e             status;

  modport source (output valid, output block_addr, output status, input ready);
  modport sink   (input valid, input block_addr, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool: free ring and allocation map in synchronous memories.
// ----------------------------------------------------------------------------
// Allocate: ring read, index times stride, base add, output register; one request
//   at a time. Release: an 8-step shift/subtract index divider, commit, output;
//   with block_stride zero a scan of the allocation map instead of the divider.
// Rejected requests (too large, empty ring, null release) go straight to output.
// Reset (async, low) and a blocks_in_use write start a clear of the whole
//   allocation map with input held off; the free ring relies on a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  fbpa_req_if.sink                              req_i,
  fbpa_rsp_if.source                            rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_W  = fbpa_pkg::IDX_W;
  localparam int CNT_W  = fbpa_pkg::CNT_W;
  localparam int ADDR_W = fbpa_pkg::ADDR_W;
  localparam int LIM_W  = fbpa_pkg::LIM_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waits for a request transfer
  localparam logic [2:0] S_RD    = 3'd1;  // ring read data is back
  localparam logic [2:0] S_ADD   = 3'd2;  // base plus product
  localparam logic [2:0] S_DIV   = 3'd3;  // one quotient bit per cycle
  localparam logic [2:0] S_SCAN  = 3'd4;  // zero stride: lowest allocated index
  localparam logic [2:0] S_CHECK = 3'd5;  // release commit
  localparam logic [2:0] S_OUT   = 3'd6;  // hand result to output register
  localparam logic [2:0] S_CLR   = 3'd7;  // clearing pass over the allocation map

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]                      state_q, state_d;

  logic [fbpa_pkg::SIZE_W-1:0]     bsize_q, bsize_d;
  logic [fbpa_pkg::STRIDE_W-1:0]   stride_q, stride_d;
  logic [ADDR_W-1:0]               base_q, base_d;

  // ring bookkeeping; ring_n_q is the saturated pool size of the last rebuild
  logic [IDX_W-1:0]                head_q, head_d;
  logic [IDX_W-1:0]                tail_q, tail_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [CNT_W-1:0]                ring_n_q, ring_n_d;
  // ring entries written since rebuild, counted from position ring_n
  logic [CNT_W-1:0]                wcnt_q, wcnt_d;
  // allocation map entry being cleared
  logic [IDX_W-1:0]                clr_q, clr_d;

  // work registers
  logic [LIM_W-1:0]                rem_q, rem_d;
  logic [LIM_W-1:0]                dsr_q, dsr_d;
  logic [IDX_W-1:0]                quo_q, quo_d;
  logic [LIM_W-1:0]                prod_q, prod_d;
  logic [ADDR_W-1:0]               res_addr_q, res_addr_d;
  fbpa_pkg::status_e               res_status_q, res_status_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]               out_addr_q, out_addr_d;
  fbpa_pkg::status_e               out_status_q, out_status_d;

  // free ring memory
  logic [IDX_W-1:0]                ring_mem [fbpa_pkg::MAX_BLOCKS];
  logic [IDX_W-1:0]                rd_data_q;
  logic                            mem_re;
  logic                            mem_we;

  // allocation map memory; read address is always quo_d
  logic                            map_mem [fbpa_pkg::MAX_BLOCKS];
  logic                            map_rd_q;
  logic                            map_re;
  logic                            map_we;
  logic [IDX_W-1:0]                map_waddr;
  logic                            map_wdata;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                            in_xfer;
  logic [ADDR_W-1:0]               off;
  logic [LIM_W-1:0]                lim;
  logic                            head_written;
  logic [IDX_W-1:0]                head_rel;
  logic [IDX_W-1:0]                alloc_idx;
  logic                            rel_ok;
  logic [CNT_W-1:0]                new_n;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;

  assign off = req_i.release_addr - base_q;
  // 256 * stride: first offset from base past the 256-block range
  assign lim = {stride_q, {IDX_W{1'b0}}};

  // A ring position not yet rewritten since rebuild is read as its own
  // index. Only positions below ring_n are ever read in that condition.
  assign head_rel     = head_q - ring_n_q[IDX_W-1:0];
  assign head_written = ({1'b0, head_rel} < wcnt_q);
  assign alloc_idx    = head_written ? rd_data_q : head_q;

  assign rel_ok = (rem_q == '0) && map_rd_q &&
                  (count_q < CNT_W'(fbpa_pkg::MAX_BLOCKS));

  assign new_n = (32'(cfg_data_i[fbpa_pkg::BIU_W-1:0]) > 32'(fbpa_pkg::MAX_BLOCKS)) ?
                 CNT_W'(fbpa_pkg::MAX_BLOCKS) :
                 CNT_W'(cfg_data_i[fbpa_pkg::BIU_W-1:0]);

  always_comb begin
    state_d      = state_q;
    bsize_d      = bsize_q;
    stride_d     = stride_q;
    base_d       = base_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    ring_n_d     = ring_n_q;
    wcnt_d       = wcnt_q;
    clr_d        = clr_q;
    rem_d        = rem_q;
    dsr_d        = dsr_q;
    quo_d        = quo_q;
    prod_d       = prod_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    map_re       = 1'b0;
    map_we       = 1'b0;
    map_waddr    = quo_q;
    map_wdata    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_addr_d = '0;
          quo_d      = '0;
          state_d    = S_OUT;
          if (req_i.cmd == fbpa_pkg::CMD_ALLOC) begin
            if (req_i.req_size > bsize_q) begin
              res_status_d = fbpa_pkg::ST_TOO_LARGE;
            end else if (count_q == '0) begin
              res_status_d = fbpa_pkg::ST_OUT_OF_BLOCKS;
            end else begin
              mem_re  = 1'b1;
              state_d = S_RD;
            end
          end else begin
            if (req_i.release_addr == '0) begin
              res_status_d = fbpa_pkg::ST_NULL_RELEASE;
            end else if (stride_q == '0) begin
              // every block sits at base: release the lowest allocated one
              rem_d = '0;
              if (off == '0) begin
                map_re  = 1'b1;
                state_d = S_SCAN;
              end else begin
                res_status_d = fbpa_pkg::ST_NOT_ALLOCATED;
              end
            end else if (off >= ADDR_W'(lim)) begin
              res_status_d = fbpa_pkg::ST_NOT_ALLOCATED;
            end else begin
              // offset below 256 * stride: the match, if any, is unique
              rem_d   = off[LIM_W-1:0];
              dsr_d   = LIM_W'(stride_q) << (IDX_W - 1);
              state_d = S_DIV;
            end
          end
        end
      end

      S_RD: begin
        map_we    = 1'b1;
        map_waddr = alloc_idx;
        map_wdata = 1'b1;
        head_d    = head_q + 1'b1;
        count_d   = count_q - 1'b1;
        prod_d    = LIM_W'(LIM_W'(alloc_idx) * LIM_W'(stride_q));
        state_d   = S_ADD;
      end

      S_ADD: begin
        res_addr_d   = base_q + ADDR_W'(prod_q);
        res_status_d = fbpa_pkg::ST_OK;
        state_d      = S_OUT;
      end

      S_DIV: begin
        if (rem_q >= dsr_q) begin
          rem_d = rem_q - dsr_q;
          quo_d = {quo_q[IDX_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[IDX_W-2:0], 1'b0};
        end
        dsr_d = dsr_q >> 1;
        if (dsr_q == LIM_W'(stride_q)) begin
          // last quotient bit: fetch the map entry of the final index
          map_re  = 1'b1;
          state_d = S_CHECK;
        end
      end

      S_SCAN: begin
        // map data trails quo by one read; a hit keeps the read port idle so
        // the data is still there for the commit
        if (map_rd_q) begin
          state_d = S_CHECK;
        end else if (quo_q == IDX_W'(fbpa_pkg::MAX_BLOCKS - 1)) begin
          res_status_d = fbpa_pkg::ST_NOT_ALLOCATED;
          state_d      = S_OUT;
        end else begin
          quo_d  = quo_q + 1'b1;
          map_re = 1'b1;
        end
      end

      S_CHECK: begin
        if (rel_ok) begin
          mem_we    = 1'b1;
          map_we    = 1'b1;
          map_waddr = quo_q;
          map_wdata = 1'b0;
          tail_d    = tail_q + 1'b1;
          count_d   = count_q + 1'b1;
          if (wcnt_q != CNT_W'(fbpa_pkg::MAX_BLOCKS)) begin
            wcnt_d = wcnt_q + 1'b1;
          end
          res_status_d = fbpa_pkg::ST_OK;
        end else begin
          res_status_d = fbpa_pkg::ST_NOT_ALLOCATED;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(fbpa_pkg::MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // configuration writes must arrive only while idle; the block does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbpa_pkg::REG_BLOCK_SIZE:   bsize_d  = cfg_data_i[fbpa_pkg::SIZE_W-1:0];
        fbpa_pkg::REG_BLOCK_STRIDE: stride_d = cfg_data_i[fbpa_pkg::STRIDE_W-1:0];
        fbpa_pkg::REG_BASE_ADDRESS: base_d   = cfg_data_i[ADDR_W-1:0];
        fbpa_pkg::REG_BLOCKS_IN_USE: begin
          ring_n_d = new_n;
          head_d   = '0;
          tail_d   = new_n[IDX_W-1:0];
          count_d  = new_n;
          wcnt_d   = '0;
          clr_d    = '0;
          state_d  = S_CLR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      bsize_q      <= fbpa_pkg::RST_BLOCK_SIZE;
      stride_q     <= fbpa_pkg::RST_STRIDE;
      base_q       <= fbpa_pkg::RST_BASE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
      ring_n_q     <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
      wcnt_q       <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bsize_q      <= bsize_d;
      stride_q     <= stride_d;
      base_q       <= base_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      ring_n_q     <= ring_n_d;
      wcnt_q       <= wcnt_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    dsr_q        <= dsr_d;
    quo_q        <= quo_d;
    prod_q       <= prod_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  // free ring: one write port at the tail, one read port at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[tail_q] <= quo_q;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[head_q];
    end
  end

  // allocation map: one write port, one read port
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q <= map_mem[quo_d];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.block_addr = out_addr_q;
  assign rsp_o.status     = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // free count never exceeds the pool size of the last rebuild
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ring_n_q)
    else $error("free count above pool size");

  // a failed result never carries an address
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && res_status_q != fbpa_pkg::ST_OK) |-> (res_addr_q == '0))
    else $error("non-ok result with nonzero address");

  // a release commits only on a block marked allocated
  a_rel_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> map_rd_q)
    else $error("release of a block not marked allocated");

  // fill count never passes the ring depth
  a_wcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= CNT_W'(fbpa_pkg::MAX_BLOCKS))
    else $error("ring fill count overflow");

endmodule

`default_nettype wire
